// File: design/hcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables for the HSV cone color distance pipeline.
package hcd_pkg;

	localparam int OUT_FRAC_BITS_DEF = 14;

	localparam int CONE_LAT = 18;
	localparam int PIPE_DEPTH = 30;

	localparam int CORDIC_STEPS = 16;
	localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032875;

	localparam int ATAN_Q16 [CORDIC_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	localparam logic signed [17:0] DEG90_Q8 = 18'sd23040;
	localparam logic signed [17:0] DEG270_Q8 = 18'sd69120;
	localparam logic signed [17:0] DEG360_Q8 = 18'sd92160;
	localparam logic signed [17:0] HUE_BASE_G = 18'sd30720;
	localparam logic signed [17:0] HUE_BASE_B = 18'sd61440;
	localparam logic signed [25:0] DEG180_Q16 = 26'sd11796480;
	localparam logic signed [25:0] DEG360_Q16 = 26'sd23592960;

	typedef enum logic [2:0] {
		SEC_R = 3'b001,
		SEC_G = 3'b010,
		SEC_B = 3'b100
	} sector_t;

	typedef struct packed {
		logic [23:0] color_a;
		logic [23:0] color_b;
	} hcd_in_t;

	typedef struct packed {
		logic [15:0] distance;
		logic [17:0] distance_squared;
	} hcd_out_t;

	typedef struct packed {
		logic signed [18:0] x;
		logic signed [18:0] y;
		logic [16:0] z;
	} cone_pt_t;

endpackage

// File: design/hcd_cone.sv
`timescale 1ns / 1ps
// Maps one packed RGB color onto the HSV cone through an eighteen-stage pipeline.
module hcd_cone (
	input logic clk,
	input logic en,
	input logic [23:0] color,
	output hcd_pkg::cone_pt_t pt
);
	import hcd_pkg::*;

	localparam logic [32:0] RV_RECIP = 33'((64'd1 << 48) / 64'd65025);
	localparam logic [32:0] RV_DIV = 33'd65025;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [25:0] a;
	} rot_t;

	function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
		input logic [7:0] dv);
		logic [8:0] t;
		t = {rem, nb};
		if (t >= {1'b0, dv}) return {1'b1, 8'(t - {1'b0, dv})};
		return {1'b0, t[7:0]};
	endfunction

	function automatic rot_t rot_step(input rot_t v, input int i);
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [25:0] a;
		rot_t o;
		x = v.x;
		y = v.y;
		a = v.a;
		if (a >= 0) begin
			o.x = x - (y >>> i);
			o.y = y + (x >>> i);
			o.a = a - 26'(ATAN_Q16[i]);
		end else begin
			o.x = x + (y >>> i);
			o.y = y - (x >>> i);
			o.a = a + 26'(ATAN_Q16[i]);
		end
		return o;
	endfunction

	logic [7:0] r, g, b, hi, lo;
	sector_t sec;
	logic signed [8:0] diff;
	logic [7:0] adiff;

	always_comb begin
		r = color[23:16];
		g = color[15:8];
		b = color[7:0];
		hi = (r >= g && r >= b) ? r : ((g >= b && g >= r) ? g : b);
		lo = (r <= g && r <= b) ? r : ((g <= b && g <= r) ? g : b);
		if (r >= g && r >= b) begin
			sec = SEC_R;
			diff = $signed({1'b0, g}) - $signed({1'b0, b});
		end else if (g >= r && g >= b) begin
			sec = SEC_G;
			diff = $signed({1'b0, b}) - $signed({1'b0, r});
		end else begin
			sec = SEC_B;
			diff = $signed({1'b0, r}) - $signed({1'b0, g});
		end
		adiff = diff[8] ? 8'(-diff) : diff[7:0];
	end

	logic [7:0] span_s1;
	logic dneg_s1;
	sector_t sec_s1;
	logic [21:0] num_s1;
	logic [15:0] prod_s1;
	logic [16:0] z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			span_s1 <= hi - lo;
			dneg_s1 <= diff[8];
			sec_s1 <= sec;
			num_s1 <= {adiff, 14'b0} - {4'b0, adiff, 10'b0};
			prod_s1 <= 16'((hi - lo) * hi);
			z_s1 <= 17'({hi, hi}) + 17'(hi == 8'hFF);
		end
	end

	logic [16:0] rvq0_s2;
	logic [15:0] prod_s2;
	logic [48:0] rv_mul;
	logic [32:0] rv_rem;
	logic [16:0] rv_d [3:17];
	logic [16:0] z_d [2:17];

	assign rv_mul = 49'(prod_s1) * 49'(RV_RECIP);
	assign rv_rem = {1'b0, prod_s2, 16'b0} - 33'(rvq0_s2) * RV_DIV;

	always_ff @(posedge clk) begin
		if (en) begin
			rvq0_s2 <= rv_mul[48:32];
			prod_s2 <= prod_s1;
			rv_d[3] <= (rv_rem >= RV_DIV) ? rvq0_s2 + 17'd1 : rvq0_s2;
			z_d[2] <= z_s1;
			z_d[3] <= z_d[2];
			for (int k = 4; k <= 17; k++) begin
				rv_d[k] <= rv_d[k - 1];
				z_d[k] <= z_d[k - 1];
			end
		end
	end

	logic [7:0] drem [0:7];
	logic [13:0] dquo [0:7];
	logic [13:0] dnum [0:7];
	logic [7:0] dspan [0:7];
	logic ddneg [0:7];
	sector_t dsec [0:7];

	assign drem[0] = num_s1[21:14];
	assign dquo[0] = '0;
	assign dnum[0] = num_s1[13:0];
	assign dspan[0] = span_s1;
	assign ddneg[0] = dneg_s1;
	assign dsec[0] = sec_s1;

	for (genvar j = 0; j < 7; j++) begin : g_div
		logic [8:0] st1, st2;
		assign st1 = div_step(drem[j], dnum[j][13], dspan[j]);
		assign st2 = div_step(st1[7:0], dnum[j][12], dspan[j]);
		always_ff @(posedge clk) begin
			if (en) begin
				drem[j + 1] <= st2[7:0];
				dquo[j + 1] <= {dquo[j][11:0], st1[8], st2[8]};
				dnum[j + 1] <= {dnum[j][11:0], 2'b00};
				dspan[j + 1] <= dspan[j];
				ddneg[j + 1] <= ddneg[j];
				dsec[j + 1] <= dsec[j];
			end
		end
	end

	logic signed [17:0] hq, hv;
	logic signed [25:0] hang, ang;
	logic negf;

	always_comb begin
		hq = ddneg[7] ? -$signed({4'b0, dquo[7]}) : $signed({4'b0, dquo[7]});
		unique case (dsec[7])
			SEC_R: hv = hq;
			SEC_G: hv = HUE_BASE_G + hq;
			SEC_B: hv = HUE_BASE_B + hq;
			default: hv = hq;
		endcase
		if (hv < 0) hv = hv + DEG360_Q8;
		hang = {hv, 8'b0};
		negf = 1'b0;
		ang = hang;
		if (hv > DEG90_Q8 && hv <= DEG270_Q8) begin
			ang = hang - DEG180_Q16;
			negf = 1'b1;
		end else if (hv > DEG270_Q8) begin
			ang = hang - DEG360_Q16;
		end
	end

	rot_t crot [0:8];
	logic cneg [0:8];

	always_ff @(posedge clk) begin
		if (en) begin
			crot[0] <= '{x: CORDIC_GAIN_Q30, y: 33'sd0, a: ang};
			cneg[0] <= negf;
		end
	end

	for (genvar k = 0; k < 8; k++) begin : g_rot
		rot_t mid, fin;
		assign mid = rot_step(crot[k], 2 * k);
		assign fin = rot_step(mid, 2 * k + 1);
		always_ff @(posedge clk) begin
			if (en) begin
				crot[k + 1] <= fin;
				cneg[k + 1] <= cneg[k];
			end
		end
	end

	logic signed [32:0] cosv, sinv, cx, cy;
	logic signed [50:0] px, py;

	always_comb begin
		cx = crot[8].x;
		cy = crot[8].y;
		cosv = cneg[8] ? -cx : cx;
		sinv = cneg[8] ? -cy : cy;
		px = cosv * $signed({1'b0, rv_d[17]});
		py = sinv * $signed({1'b0, rv_d[17]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt.x <= px[48:30];
			pt.y <= py[48:30];
			pt.z <= z_d[17];
		end
	end

endmodule

// File: design/hsv_cone_color_distance.sv
`timescale 1ns / 1ps
// Top level: two cone mappings, squared distance and a pipelined square root.
// Throughput is one item per cycle; the whole pipeline halts only while a result waits
// at the output under stall, and bubbles travel as cleared valid bits.
// Reset clears only the valid bits; data registers are not reset.
module hsv_cone_color_distance #(
	parameter int OUT_FRAC_BITS = hcd_pkg::OUT_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input hcd_pkg::hcd_in_t req_data,
	output logic rsp_valid,
	input logic rsp_stall,
	output hcd_pkg::hcd_out_t rsp_data
);
	import hcd_pkg::*;

	localparam int SHL = (2 * OUT_FRAC_BITS >= 32) ? 2 * OUT_FRAC_BITS - 32 : 0;
	localparam int SHR = (2 * OUT_FRAC_BITS < 32) ? 32 - 2 * OUT_FRAC_BITS : 0;
	localparam int DSQ_SH = 32 - OUT_FRAC_BITS;

	function automatic logic [32:0] sqrt_step(input logic [16:0] rem, input logic [15:0] root,
		input logic [1:0] pair);
		logic [18:0] rr;
		logic [18:0] t;
		rr = {rem, pair};
		t = {1'b0, root, 2'b01};
		if (rr >= t) return {17'(rr - t), root[14:0], 1'b1};
		return {rr[16:0], root[14:0], 1'b0};
	endfunction

	logic en;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en = !(rsp_valid && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], req_valid};
		end
	end

	cone_pt_t pt_a, pt_b;

	hcd_cone u_cone_a (.clk(clk), .en(en), .color(req_data.color_a), .pt(pt_a));
	hcd_cone u_cone_b (.clk(clk), .en(en), .color(req_data.color_b), .pt(pt_b));

	logic signed [19:0] dx_s19, dy_s19;
	logic signed [17:0] dz_s19;
	logic signed [39:0] sqx_c, sqy_c, sqz_c;
	logic [39:0] sqx_s20, sqy_s20, sqz_s20;
	logic [41:0] sum_s21;
	logic [41:0] dsq_full;
	logic [63:0] scaled;
	logic [17:0] dsq_s22;
	logic sat_s22;
	logic [31:0] rad_s22;

	always_comb begin
		sqx_c = dx_s19 * dx_s19;
		sqy_c = dy_s19 * dy_s19;
		sqz_c = dz_s19 * dz_s19;
		dsq_full = sum_s21 >> DSQ_SH;
		scaled = (64'(sum_s21) << SHL) >> SHR;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s19 <= 20'(pt_b.x) - 20'(pt_a.x);
			dy_s19 <= 20'(pt_b.y) - 20'(pt_a.y);
			dz_s19 <= $signed({1'b0, pt_b.z}) - $signed({1'b0, pt_a.z});
			sqx_s20 <= sqx_c;
			sqy_s20 <= sqy_c;
			sqz_s20 <= sqz_c;
			sum_s21 <= 42'(sqx_s20) + 42'(sqy_s20) + 42'(sqz_s20);
			dsq_s22 <= (|dsq_full[41:18]) ? '1 : dsq_full[17:0];
			sat_s22 <= |scaled[63:32];
			rad_s22 <= scaled[31:0];
		end
	end

	logic [31:0] sq_rad [0:8];
	logic [16:0] sq_rem [0:8];
	logic [15:0] sq_root [0:8];
	logic sq_sat [0:8];
	logic [17:0] sq_dsq [0:8];

	assign sq_rad[0] = rad_s22;
	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;
	assign sq_sat[0] = sat_s22;
	assign sq_dsq[0] = dsq_s22;

	for (genvar k = 0; k < 8; k++) begin : g_sqrt
		logic [32:0] st1, st2;
		assign st1 = sqrt_step(sq_rem[k], sq_root[k], sq_rad[k][31:30]);
		assign st2 = sqrt_step(st1[32:16], st1[15:0], sq_rad[k][29:28]);
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem[k + 1] <= st2[32:16];
				sq_root[k + 1] <= st2[15:0];
				sq_rad[k + 1] <= {sq_rad[k][27:0], 4'b0};
				sq_sat[k + 1] <= sq_sat[k];
				sq_dsq[k + 1] <= sq_dsq[k];
			end
		end
	end

	assign rsp_data.distance = sq_sat[8] ? '1 : sq_root[8];
	assign rsp_data.distance_squared = sq_dsq[8];

	a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("Input stalled without a stalled result at the output.");

	a_sqrt_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (sq_rem[8] <= {sq_root[8], 1'b0}))
		else $error("Square root remainder exceeds twice the root.");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the HSV cone color distance pipeline.
module tb_top;
	import hcd_pkg::*;

	localparam int FRAC = OUT_FRAC_BITS_DEF;
	localparam int LATENCY = 30;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	hcd_in_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	hcd_out_t rsp_data;

	hcd_out_t expected_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	longint cycles = 0;
	bit sink_idles = 1'b0;
	bit sink_hold = 1'b0;
	bit src_idles = 1'b0;

	hsv_cone_color_distance u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void cone_point(input logic [23:0] rgb, output longint px,
			output longint py, output longint pz);
		int r, g, b, hi, lo, span, h, diff, base;
		longint ang, x, y, nx, rv;
		bit flip;
		int atan_tab [16] = '{2949120, 1740967, 919879, 466945, 234379, 117266, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
		r = int'(rgb[23:16]);
		g = int'(rgb[15:8]);
		b = int'(rgb[7:0]);
		hi = (r >= g && r >= b) ? r : ((g >= b && g >= r) ? g : b);
		lo = (r <= g && r <= b) ? r : ((g <= b && g <= r) ? g : b);
		span = hi - lo;
		h = 0;
		if (span != 0) begin
			if (r >= g && r >= b) begin
				base = 0; diff = g - b;
			end else if (g >= r && g >= b) begin
				base = 120; diff = b - r;
			end else begin
				base = 240; diff = r - g;
			end
			h = base * 256 + (diff * 15360) / span;
			if (h < 0) h += 92160;
		end
		ang = longint'(h) * 256;
		flip = 1'b0;
		if (ang > 90 * 65536 && ang <= 270 * 65536) begin
			ang -= 180 * 65536;
			flip = 1'b1;
		end else if (ang > 270 * 65536) begin
			ang -= 360 * 65536;
		end
		x = 652032875;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (ang >= 0) begin
				nx = x - fshift(y, i);
				y = y + fshift(x, i);
				ang -= atan_tab[i];
			end else begin
				nx = x + fshift(y, i);
				y = y - fshift(x, i);
				ang += atan_tab[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		rv = (longint'(span) * hi * 65536) / 65025;
		px = fshift(x * rv, 30);
		py = fshift(y * rv, 30);
		pz = (longint'(hi) * 65536) / 255;
	endfunction

	function automatic hcd_out_t predict_distance(hcd_in_t item);
		longint ax, ay, az, bx, by, bz, dx, dy, dz;
		longint unsigned sum, dsq, scaled, root_val;
		hcd_out_t res;
		cone_point(item.color_a, ax, ay, az);
		cone_point(item.color_b, bx, by, bz);
		dx = bx - ax;
		dy = by - ay;
		dz = bz - az;
		sum = dx * dx + dy * dy + dz * dz;
		dsq = sum >> (32 - FRAC);
		if (2 * FRAC >= 32) scaled = sum << (2 * FRAC - 32);
		else scaled = sum >> (32 - 2 * FRAC);
		root_val = root_floor(scaled);
		res.distance = root_val > 64'hFFFF ? 16'hFFFF : root_val[15:0];
		res.distance_squared = dsq > 64'h3FFFF ? 18'h3FFFF : dsq[17:0];
		return res;
	endfunction

	// The sender randomly drops valid between transfers only when src_idles is set.
	task automatic send_pair(input logic [23:0] ca, input logic [23:0] cb);
		hcd_in_t item;
		item.color_a = ca;
		item.color_b = cb;
		while (src_idles && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_q.push_back(predict_distance(item));
		n_sent++;
	endtask

	task automatic drain();
		while (expected_q.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (sink_hold) rsp_stall <= 1'b1;
		else rsp_stall <= sink_idles && ($urandom_range(99) < 14);
	end

	always @(posedge clk) begin
		hcd_out_t exp_res;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, rsp_data);
				errors++;
			end else begin
				exp_res = expected_q.pop_front();
				n_checked++;
				if (rsp_data.distance !== exp_res.distance) begin
					$display("%0t: distance expected %h actual %h", $time,
						exp_res.distance, rsp_data.distance);
					errors++;
				end
				if (rsp_data.distance_squared !== exp_res.distance_squared) begin
					$display("%0t: distance_squared expected %h actual %h", $time,
						exp_res.distance_squared, rsp_data.distance_squared);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		logic [23:0] edge_colors [12] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
			24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'hFF0080,
			24'h01FF00, 24'h0100FF};
		send_pair(24'h000000, 24'hFFFFFF);
		send_pair(24'hFF0000, 24'h00FFFF);
		send_pair(24'h0000FF, 24'hFFFF00);
		send_pair(24'hAAAAAA, 24'h555555);
		send_pair(24'hFFFF00, 24'hFF00FF);
		send_pair(24'h00FFFF, 24'hFF00FF);
		send_pair(24'hFFFFFE, 24'h000001);
		for (int i = 0; i < 12; i++) send_pair(edge_colors[i], edge_colors[11 - i]);
		req_valid <= 1'b0;
		drain();
	endtask

	task automatic test_random();
		src_idles = 1'b1;
		sink_idles = 1'b1;
		for (int i = 0; i < 700; i++)
			send_pair(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)));
		req_valid <= 1'b0;
		drain();
	endtask

	task automatic test_back_to_back();
		src_idles = 1'b0;
		sink_idles = 1'b0;
		for (int i = 0; i < 60; i++)
			send_pair(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)));
		req_valid <= 1'b0;
		drain();
	endtask

	// Receiver holds off long enough that the pipeline fills and stalls its input.
	task automatic test_backpressure();
		fork
			begin
				sink_hold = 1'b1;
				repeat (80) @(posedge clk);
				sink_hold = 1'b0;
			end
			begin
				for (int i = 0; i < 70; i++)
					send_pair(24'($urandom_range(24'hFFFFFF)),
						24'($urandom_range(24'hFFFFFF)));
				req_valid <= 1'b0;
			end
		join
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_backpressure();
		test_random();
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d color pairs, checked %0d results; directed, burst,", n_sent,
			n_checked);
		$display("long receiver hold-off and random idling on both sides.");
		if (errors == 0 && expected_q.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end
endmodule

// File: filelist.f
design/hcd_pkg.sv
design/hcd_cone.sv
design/hsv_cone_color_distance.sv
dv/tb_top.sv
